// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked at the same clock edge.
`define SORTRK_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked at the clock edge that follows the antecedent.
`define SORTRK_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sortrk_pkg.sv =====
// Shared types, constants and helper function of the reference tracker.
package sortrk_pkg;

   localparam int DATA_W        = 32;
   localparam int LIM_W         = 31;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int FRAC_BITS_DEF = 20;
   localparam int CSR_IDX_W     = 3;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [LIM_W-1:0]         ulim_type;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DAMPING = 3'd0,
      CSR_SPRING  = 3'd1,
      CSR_LEAD    = 3'd2,
      CSR_LIMIT   = 3'd3,
      CSR_STEP    = 3'd4
   } csr_index_type;

   // Reset values (Q12.20)
   localparam word_type DAMPING_RST = -32'sd6606029;
   localparam word_type SPRING_RST  = -32'sd12845056;
   localparam word_type LEAD_RST    = -32'sd385352;
   localparam ulim_type LIMIT_RST   = 31'd85598;
   localparam ulim_type STEP_RST    = 31'd17476;
   localparam word_type POS_XY_RST  = 32'sd855980;
   localparam word_type POS_Z_RST   = 32'sd0;

   // Coefficient set seen by every lane
   typedef struct packed {
      word_type damping;
      word_type spring;
      word_type lead;
      ulim_type limit;
      ulim_type step;
   } coef_type;

   // Step strobes from the sequencer to the lanes and the merge stage
   typedef struct packed {
      logic load;
      logic mul_damp;
      logic mul_spring;
      logic mul_rate;
      logic mul_dstep;
      logic mul_spos;
      logic mul_lead;
      logic push;
   } lane_ctl_type;

   // Saturate a wide signed value to the 32-bit range
   function automatic word_type sat_word(input logic signed [PROD_W-1:0] v);
      word_type res;
      if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
         res = v[DATA_W-1:0];
      end else if (v[PROD_W-1]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== src/sortrk_req_if.sv =====
// Request channel: one tick of reference positions for three axes.
interface sortrk_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       ref_x;
   logic signed [31:0]       ref_y;
   logic signed [31:0]       ref_z;

   modport source (output valid, output ref_x, output ref_y, output ref_z, input ready);
   modport sink   (input valid, input ref_x, input ref_y, input ref_z, output ready);
endinterface

// ===== src/sortrk_rsp_if.sv =====
// Response channel: modelled positions for three axes after one tick.
interface sortrk_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       pos_x;
   logic signed [31:0]       pos_y;
   logic signed [31:0]       pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== src/sortrk_lane.sv =====
// One axis lane: two integrator states and a shared multiplier stepped by the sequencer.
module sortrk_lane #(
   parameter int FRAC_BITS = sortrk_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sortrk_pkg::lane_ctl_type ctl,
   input  sortrk_pkg::coef_type   coef,
   input  logic                   clamp_en,
   input  sortrk_pkg::word_type   pos_reset,
   input  sortrk_pkg::word_type   ref_in,
   output sortrk_pkg::word_type   pos_out
);

   sortrk_pkg::word_type rate_ff, pos_ff;
   sortrk_pkg::word_type ref_ff, d1_ff;
   sortrk_pkg::word_type prod_a_ff, prod_b_ff, prod_c_ff;

   sortrk_pkg::word_type mul_a, mul_b, mul_res, step_s, lim_s, lim_n;
   sortrk_pkg::word_type d1_in, pos_in, rate_sum, rate_in;
   logic signed [sortrk_pkg::PROD_W-1:0] prod_full, prod_shift;

   assign step_s = {1'b0, coef.step};
   assign lim_s  = {1'b0, coef.limit};
   assign lim_n  = -lim_s;

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = coef.damping;
      mul_b = rate_ff;
      if (ctl.mul_spring || ctl.mul_spos) begin
         mul_a = coef.spring;
         mul_b = pos_ff;
      end else if (ctl.mul_rate) begin
         mul_a = rate_ff;
         mul_b = step_s;
      end else if (ctl.mul_dstep) begin
         mul_a = d1_ff;
         mul_b = step_s;
      end else if (ctl.mul_lead) begin
         mul_a = coef.lead;
         mul_b = rate_ff;
      end
   end

   // Fixed-point product: floor shift, then saturate
   assign prod_full  = mul_a * mul_b;
   assign prod_shift = prod_full >>> FRAC_BITS;
   assign mul_res    = sortrk_pkg::sat_word(prod_shift);

   // Derivative, Euler updates and the output combination
   assign d1_in = sortrk_pkg::sat_word(sortrk_pkg::PROD_W'(prod_a_ff)
                  + sortrk_pkg::PROD_W'(prod_b_ff) + sortrk_pkg::PROD_W'(ref_ff));
   assign pos_in   = sortrk_pkg::sat_word(sortrk_pkg::PROD_W'(pos_ff)
                     + sortrk_pkg::PROD_W'(prod_c_ff));
   assign rate_sum = sortrk_pkg::sat_word(sortrk_pkg::PROD_W'(rate_ff)
                     + sortrk_pkg::PROD_W'(prod_a_ff));
   assign pos_out  = sortrk_pkg::sat_word(sortrk_pkg::PROD_W'(prod_a_ff)
                     - sortrk_pkg::PROD_W'(prod_b_ff));

   // Rate clamp for the horizontal axes
   always_comb begin
      rate_in = rate_sum;
      if (clamp_en && (rate_sum < lim_n)) begin
         rate_in = lim_n;
      end else if (clamp_en && (rate_sum > lim_s)) begin
         rate_in = lim_s;
      end
   end

   // Integrator states
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         pos_ff  <= pos_reset;
      end else begin
         if (ctl.mul_dstep) begin
            pos_ff <= pos_in;
         end
         if (ctl.mul_spos) begin
            rate_ff <= rate_in;
         end
      end
   end

   // Product and operand registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ref_ff <= ref_in;
      end
      if (ctl.mul_damp || ctl.mul_dstep || ctl.mul_lead) begin
         prod_a_ff <= mul_res;
      end
      if (ctl.mul_spring || ctl.mul_spos) begin
         prod_b_ff <= mul_res;
      end
      if (ctl.mul_rate) begin
         prod_c_ff <= mul_res;
         d1_ff     <= d1_in;
      end
   end

endmodule

// ===== src/sortrk_merge.sv =====
// Merge stage: gathers the three lane results into one response word register.
module sortrk_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  sortrk_pkg::lane_ctl_type ctl,
   input  sortrk_pkg::word_type   lane_x,
   input  sortrk_pkg::word_type   lane_y,
   input  sortrk_pkg::word_type   lane_z,
   output logic                   can_push,
   sortrk_rsp_if.source           rsp_if
);

   logic                 valid_ff;
   sortrk_pkg::word_type pos_x_ff, pos_y_ff, pos_z_ff;

   // Room when empty or when the held word leaves this cycle
   assign can_push = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.push) begin
         valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         pos_x_ff <= lane_x;
         pos_y_ff <= lane_y;
         pos_z_ff <= lane_z;
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.pos_x = pos_x_ff;
   assign rsp_if.pos_y = pos_y_ff;
   assign rsp_if.pos_z = pos_z_ff;

endmodule

// ===== src/second_order_reference_tracker.sv =====
// Top level of the second order reference tracker: registers, sequencer, lanes and merge.
//
// Three axis lanes advance a forward Euler model of a second order reference response in
// lockstep, one request word (ref_x, ref_y, ref_z) at a time. Each lane owns one 32x32
// multiplier; the six dependent products of a tick (damping, spring, rate, dstep, spos,
// lead) pass through it in turn, then the response word is pushed and only then is the
// next request taken. A response still waiting in the output register only holds the
// lanes if a second result is ready before it is taken. The x and y rate states are
// clamped to plus or minus the limit register, the z axis is not. All values are signed
// fixed point with FRAC_BITS fractional bits and saturate. Registers are written through
// csr_we, csr_index and csr_wdata and must only change while no request is in progress.
module second_order_reference_tracker #(
   parameter int FRAC_BITS = sortrk_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   sortrk_req_if.sink                         req_if,
   sortrk_rsp_if.source                       rsp_if,
   input  logic                               csr_we,
   input  logic [sortrk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sortrk_pkg::DATA_W-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DAMP, ST_SPRING, ST_RATE, ST_DSTEP, ST_SPOS, ST_LEAD, ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   sortrk_pkg::coef_type     coef_ff;
   sortrk_pkg::lane_ctl_type ctl;
   sortrk_pkg::word_type     lane_x, lane_y, lane_z;
   logic                     can_push, accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.damping <= sortrk_pkg::DAMPING_RST;
         coef_ff.spring  <= sortrk_pkg::SPRING_RST;
         coef_ff.lead    <= sortrk_pkg::LEAD_RST;
         coef_ff.limit   <= sortrk_pkg::LIMIT_RST;
         coef_ff.step    <= sortrk_pkg::STEP_RST;
      end else if (csr_we) begin
         case (sortrk_pkg::csr_index_type'(csr_index))
            sortrk_pkg::CSR_DAMPING: coef_ff.damping <= csr_wdata;
            sortrk_pkg::CSR_SPRING:  coef_ff.spring  <= csr_wdata;
            sortrk_pkg::CSR_LEAD:    coef_ff.lead    <= csr_wdata;
            sortrk_pkg::CSR_LIMIT:   coef_ff.limit   <= csr_wdata[sortrk_pkg::LIM_W-1:0];
            sortrk_pkg::CSR_STEP:    coef_ff.step    <= csr_wdata[sortrk_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: one multiply step per cycle, then wait for room in the merge register
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = accept ? ST_DAMP : ST_IDLE;
         ST_DAMP:   state_in = ST_SPRING;
         ST_SPRING: state_in = ST_RATE;
         ST_RATE:   state_in = ST_DSTEP;
         ST_DSTEP:  state_in = ST_SPOS;
         ST_SPOS:   state_in = ST_LEAD;
         ST_LEAD:   state_in = ST_FINISH;
         ST_FINISH: state_in = can_push ? ST_IDLE : ST_FINISH;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step strobes to the lanes
   assign ctl.load       = accept;
   assign ctl.mul_damp   = (state_ff == ST_DAMP);
   assign ctl.mul_spring = (state_ff == ST_SPRING);
   assign ctl.mul_rate   = (state_ff == ST_RATE);
   assign ctl.mul_dstep  = (state_ff == ST_DSTEP);
   assign ctl.mul_spos   = (state_ff == ST_SPOS);
   assign ctl.mul_lead   = (state_ff == ST_LEAD);
   assign ctl.push       = (state_ff == ST_FINISH) && can_push;

   sortrk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .coef      (coef_ff),
      .clamp_en  (1'b1),
      .pos_reset (sortrk_pkg::POS_XY_RST),
      .ref_in    (req_if.ref_x),
      .pos_out   (lane_x)
   );

   sortrk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .coef      (coef_ff),
      .clamp_en  (1'b1),
      .pos_reset (sortrk_pkg::POS_XY_RST),
      .ref_in    (req_if.ref_y),
      .pos_out   (lane_y)
   );

   // Vertical axis runs unclamped
   sortrk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .coef      (coef_ff),
      .clamp_en  (1'b0),
      .pos_reset (sortrk_pkg::POS_Z_RST),
      .ref_in    (req_if.ref_z),
      .pos_out   (lane_z)
   );

   sortrk_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .lane_x   (lane_x),
      .lane_y   (lane_y),
      .lane_z   (lane_z),
      .can_push (can_push),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== src/sortrk_checker.sv =====
// Port-level checks of the tracker, bound to its top level.
`include "assert_macros.svh"

module sortrk_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [31:0]  pos_x,
   input logic signed [31:0]  pos_y,
   input logic signed [31:0]  pos_z
);

   // One tick at a time: busy straight after taking a word
   `SORTRK_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

   // With the output register empty, the response follows a fixed latency
   `SORTRK_ASSERT_NOW(a_rsp_latency, req_valid && req_ready && !rsp_valid, ##8 rsp_valid, "response late or missing")

   // A stalled response word holds
   `SORTRK_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z), "stalled response changed")

endmodule

bind second_order_reference_tracker sortrk_checker u_sortrk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .pos_x     (rsp_if.pos_x),
   .pos_y     (rsp_if.pos_y),
   .pos_z     (rsp_if.pos_z)
);

// ===== tb/sv/tracker_check_pkg.sv =====
// Scoreboard class for the reference tracker: position predictor and response word checks.
package tracker_check_pkg;

   import sortrk_pkg::*;

   localparam int       FRAC     = FRAC_BITS_DEF;
   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // One response word: modelled position of each axis
   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } pos_triple_type;

   class tracker_scoreboard;

      // Mirror of the coefficient registers
      word_type damping;
      word_type spring;
      word_type lead;
      ulim_type limit;
      ulim_type step;

      // Integrator states per axis, x y z
      word_type rate_st [3];
      word_type pos_st  [3];

      pos_triple_type expected_pos [$];
      int             errors;

      function new();
         damping    = DAMPING_RST;
         spring     = SPRING_RST;
         lead       = LEAD_RST;
         limit      = LIMIT_RST;
         step       = STEP_RST;
         rate_st    = '{32'sd0, 32'sd0, 32'sd0};
         pos_st     = '{POS_XY_RST, POS_XY_RST, POS_Z_RST};
         errors     = 0;
      endfunction

      // Register write as seen by the block; spare indexes are dropped
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_DAMPING: damping = data;
            CSR_SPRING:  spring  = data;
            CSR_LEAD:    lead    = data;
            CSR_LIMIT:   limit   = data[LIM_W-1:0];
            CSR_STEP:    step    = data[LIM_W-1:0];
            default: ;
         endcase
      endfunction

      function word_type clip(longint v);
         if (v > longint'(WORD_MAX)) return WORD_MAX;
         if (v < longint'(WORD_MIN)) return WORD_MIN;
         return word_type'(v);
      endfunction

      // Fixed point product, floored, saturated
      function word_type qmul(word_type a, word_type b);
         longint p;
         p = longint'(a) * longint'(b);
         return clip(p >>> FRAC);
      endfunction

      // One forward Euler tick of one axis; returns its modelled position
      function word_type advance_axis(int k, word_type target, bit clamp_rate);
         word_type r0, p0, d1, r1, p1, dt;
         longint   lim;
         r0  = rate_st[k];
         p0  = pos_st[k];
         dt  = word_type'({1'b0, step});
         d1  = clip(longint'(qmul(damping, r0)) + longint'(qmul(spring, p0)) +
                    longint'(target));
         r1  = clip(longint'(r0) + longint'(qmul(d1, dt)));
         p1  = clip(longint'(p0) + longint'(qmul(r0, dt)));
         if (clamp_rate) begin
            lim = longint'({1'b0, limit});
            if (longint'(r1) < -lim) begin
               r1 = word_type'(-lim);
            end else if (longint'(r1) > lim) begin
               r1 = word_type'(lim);
            end
         end
         rate_st[k] = r1;
         pos_st[k]  = p1;
         return clip(longint'(qmul(lead, r1)) - longint'(qmul(spring, p1)));
      endfunction

      // Accepted request word: advance all axes and queue the expected response
      function void note_tick(word_type rx, word_type ry, word_type rz);
         pos_triple_type e;
         e.x = advance_axis(0, rx, 1'b1);
         e.y = advance_axis(1, ry, 1'b1);
         e.z = advance_axis(2, rz, 1'b0);
         expected_pos.push_back(e);
      endfunction

      function int pending();
         return expected_pos.size();
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      // Accepted response word against the oldest expectation
      task check_result(word_type px, word_type py, word_type pz);
         pos_triple_type e;
         if (expected_pos.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            e = expected_pos.pop_front();
            if (px !== e.x)
               report_mismatch($sformatf("pos_x got %0d expected %0d", px, e.x));
            if (py !== e.y)
               report_mismatch($sformatf("pos_y got %0d expected %0d", py, e.y));
            if (pz !== e.z)
               report_mismatch($sformatf("pos_z got %0d expected %0d", pz, e.z));
         end
      endtask

   endclass

endpackage

// ===== tb/sv/tb_second_order_reference_tracker.sv =====
// Testbench top for the second order reference tracker: stimulus, handshakes and checks.
module tb_second_order_reference_tracker;

   import sortrk_pkg::*;
   import tracker_check_pkg::*;

   localparam int ITEM_TARGET   = 1750;
   localparam int DRAIN_SLACK   = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PERCENT  = 29;
   localparam int END_GUARD     = 5000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_STEP + 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = {CSR_IDX_W{1'b1}};
   localparam word_type METRE = word_type'(1 << FRAC_BITS_DEF);

   typedef enum {COEF_RESET, COEF_PLANT, COEF_WILD, COEF_EDGE} coef_style_type;
   typedef enum {REF_TRACK, REF_FULL, REF_EDGE} ref_style_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DATA_W-1:0]     csr_wdata;

   sortrk_req_if req_bus ();
   sortrk_rsp_if rsp_bus ();

   tracker_scoreboard sb;
   int                items_sent = 0;
   bit                quiet_run  = 1'b0;
   int                hold_left  = 0;
   word_type          track_tgt [3] = '{32'sd0, 32'sd0, 32'sd0};

   second_order_reference_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   initial begin
      #6_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_tick(req_bus.ref_x, req_bus.ref_y, req_bus.ref_z);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.pos_z);
      end
   end

   // Receiver: random back-pressure, or a long hold-off counted down here
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet_run || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   function logic [DATA_W-1:0] edge_word();
      case ($urandom_range(5))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         4: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Reference for one axis; tracking holds a target for a while
   function word_type next_ref(ref_style_type s, int axis);
      case (s)
         REF_TRACK: begin
            if ($urandom_range(15) == 0)
               track_tgt[axis] = word_type'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            return track_tgt[axis];
         end
         REF_FULL: return word_type'($urandom);
         default:  return word_type'(edge_word());
      endcase
   endfunction

   // One request word; returns at the falling edge after it was taken, valid still high
   task send_tick(input word_type rx, input word_type ry, input word_type rz);
      while (!quiet_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ref_x <= rx;
      req_bus.ref_y <= ry;
      req_bus.ref_z <= rz;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait for every expected response word
   task wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   // Write all five registers, preceded by a write to a spare index
   task load_coefs(input logic [DATA_W-1:0] damp, input logic [DATA_W-1:0] spr,
                   input logic [DATA_W-1:0] ld, input logic [DATA_W-1:0] lim,
                   input logic [DATA_W-1:0] stp);
      logic [DATA_W-1:0]    vals [5];
      csr_index_type        regs [5];
      logic [CSR_IDX_W-1:0] spare;
      logic [DATA_W-1:0]    spare_data;
      vals       = '{damp, spr, ld, lim, stp};
      regs       = '{CSR_DAMPING, CSR_SPRING, CSR_LEAD, CSR_LIMIT, CSR_STEP};
      spare      = CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI));
      spare_data = $urandom;
      csr_we    <= 1'b1;
      csr_index <= spare;
      csr_wdata <= spare_data;
      sb.write_reg(spare, spare_data);
      @(negedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         sb.write_reg(regs[i], vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task load_style(input coef_style_type s);
      logic [DATA_W-1:0] ld;
      case (s)
         COEF_RESET:
            load_coefs(DAMPING_RST, SPRING_RST, LEAD_RST, LIMIT_RST, STEP_RST);
         COEF_PLANT: begin
            // plausible tracking dynamics, bit 31 of step left random
            ld = $urandom_range(0, 1 << 22);
            load_coefs(-$urandom_range(1 << 19, 1 << 24), -$urandom_range(1 << 20, 1 << 26),
                       $urandom_range(1) ? -ld : ld,
                       ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1 << 12, 1 << 23),
                       $urandom_range(1 << 8, 1 << 16)
                          | {$urandom_range(1) != 0, {(DATA_W-1){1'b0}}});
         end
         COEF_WILD:
            load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
         default:
            load_coefs(edge_word(), edge_word(), edge_word(), edge_word(), edge_word());
      endcase
   endtask

   task run_items(input ref_style_type rs, input int n);
      ref_style_type s;
      for (int i = 0; i < n; i++) begin
         s = (rs == REF_TRACK && $urandom_range(19) == 0) ? REF_FULL : rs;
         if (!quiet_run && $urandom_range(99) < 2)
            wait_drained();
         send_tick(next_ref(s, 0), next_ref(s, 1), next_ref(s, 2));
      end
   endtask

   initial begin
      int               guard;
      int               r;
      coef_style_type   cs;
      ref_style_type    rs;

      sb                = new();
      req_bus.valid     = 1'b0;
      req_bus.ref_x     = '0;
      req_bus.ref_y     = '0;
      req_bus.ref_z     = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at reset coefficients: field extremes, overflow, rate clamp
      send_tick(32'sd0, 32'sd0, 32'sd0);
      repeat (3) send_tick(WORD_MAX, WORD_MAX, WORD_MAX);
      repeat (3) send_tick(WORD_MIN, WORD_MIN, WORD_MIN);
      send_tick(WORD_MAX, WORD_MIN, 32'sd0);
      send_tick(-32'sd1, -32'sd1, -32'sd1);
      send_tick(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
      send_tick(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0);
      repeat (5) send_tick(10 * METRE, -10 * METRE, 3 * METRE);
      repeat (4) send_tick(-METRE, METRE, -METRE);

      // Coefficient extremes, limit and step at full scale
      wait_drained();
      load_coefs(WORD_MIN, WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      run_items(REF_FULL, 30);

      // Opposite extremes; zero limit and zero step with bit 31 set
      wait_drained();
      load_coefs(WORD_MAX, WORD_MIN, WORD_MAX, 32'h8000_0000, 32'h8000_0000);
      run_items(REF_EDGE, 30);

      // Zero clamp bound forces the x and y rate states to zero
      wait_drained();
      load_coefs(DAMPING_RST, SPRING_RST, LEAD_RST, 32'd0, STEP_RST);
      run_items(REF_TRACK, 50);

      // Long stretch with no idling on either side
      wait_drained();
      load_style(COEF_RESET);
      quiet_run = 1'b1;
      run_items(REF_TRACK, 200);
      quiet_run = 1'b0;

      // Receiver holds off while words keep coming, then a pause until drained
      wait_drained();
      load_style(COEF_PLANT);
      hold_left = HOLD_CYCLES;
      run_items(REF_TRACK, 60);
      wait_drained();
      run_items(REF_TRACK, 60);

      // Random phases
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         r  = $urandom_range(99);
         cs = (r < 55) ? COEF_PLANT : (r < 70) ? COEF_WILD : (r < 85) ? COEF_EDGE : COEF_RESET;
         if (cs == COEF_PLANT || cs == COEF_RESET || $urandom_range(3) == 0)
            rs = REF_TRACK;
         else
            rs = $urandom_range(1) ? REF_FULL : REF_EDGE;
         load_style(cs);
         quiet_run = ($urandom_range(9) == 0);
         if ($urandom_range(5) == 0)
            hold_left = HOLD_CYCLES;
         run_items(rs, $urandom_range(40, 140));
         quiet_run = 1'b0;
      end

      // Drain with a bound, then let any stray word show up
      req_bus.valid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < END_GUARD) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_SLACK) @(negedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d response words never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
